FILE: hdl/swfr_pkg.sv
// Shared types and constants for the sync-word frame receiver.
// No dependencies; every other file imports this package.
package swfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 7;
    localparam int RUN_W   = 3;

    localparam logic [BYTE_W-1:0] SYNC_BYTE_RESET = 8'hFF;

    // Receiver mode: hunting for the sync run, or inside a frame body.
    typedef enum logic {
        MODE_HUNT,
        MODE_FRAME
    } swfr_mode_t;

    // One result item as it leaves the frame logic.
    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               last;
        logic               frame_good;
    } swfr_result_t;

endpackage

FILE: hdl/swfr_if.sv
// Valid/ready channel interfaces for received bytes and frame results.
// Depends on swfr_pkg for field widths.
interface swfr_in_if;
    import swfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_error;

    modport source (output valid, output rx_byte, output rx_error, input ready);
    modport sink   (input valid, input rx_byte, input rx_error, output ready);
endinterface

interface swfr_out_if;
    import swfr_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               last;
    logic               frame_good;

    modport source (output valid, output data_byte, output byte_index, output last,
                    output frame_good, input ready);
    modport sink   (input valid, input data_byte, input byte_index, input last,
                    input frame_good, output ready);
endinterface

FILE: hdl/sync_word_frame_receiver.sv
// Sync-word frame receiver with XOR checksum, top level.
// A result appears at the output in the cycle after the byte's request is accepted.
// Throughput: one byte per cycle; the result register stalls input only when full.
// Reset (rst_n, async, active low): hunting, run count cleared, sync byte 0xFF.
// Depends on swfr_pkg, swfr_if, swfr_core and swfr_out_stage.
module sync_word_frame_receiver #(
    parameter int SYNC_LEN  = 4,
    parameter int FRAME_LEN = 86
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [swfr_pkg::BYTE_W-1:0] cfg_wdata,
    swfr_in_if.sink                     rx,
    swfr_out_if.source                  frame
);
    import swfr_pkg::*;

    logic [BYTE_W-1:0] sync_byte_reg;
    logic              accept;
    logic              free;
    logic              res_valid;
    swfr_result_t      res;

    // Sync byte configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg <= SYNC_BYTE_RESET;
        end
        else if (cfg_we)
        begin
            sync_byte_reg <= cfg_wdata;
        end
    end

    assign rx.ready = free;
    assign accept   = rx.valid && free;

    swfr_core #(
        .SYNC_LEN  (SYNC_LEN),
        .FRAME_LEN (FRAME_LEN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .rx_error  (rx.rx_error),
        .sync_byte (sync_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    swfr_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (res_valid),
        .res    (res),
        .free   (free),
        .out_ch (frame)
    );

endmodule

FILE: hdl/swfr_core.sv
// Frame state machine: sync hunt, body position, XOR accumulation.
// Depends on swfr_pkg; driven by the top level on each accepted request.
module swfr_core #(
    parameter int SYNC_LEN  = 4,
    parameter int FRAME_LEN = 86
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [swfr_pkg::BYTE_W-1:0]     rx_byte,
    input  logic                            rx_error,
    input  logic [swfr_pkg::BYTE_W-1:0]     sync_byte,
    output logic                            res_valid,
    output swfr_pkg::swfr_result_t          res
);
    import swfr_pkg::*;

    // A frame with no room for a body still carries a lone checksum byte.
    localparam int BODY_LEN = (FRAME_LEN > SYNC_LEN) ? (FRAME_LEN - SYNC_LEN) : 1;
    localparam logic [INDEX_W-1:0] LAST_POS = INDEX_W'(BODY_LEN - 1);
    localparam logic [RUN_W-1:0]   RUN_LAST = RUN_W'(SYNC_LEN - 1);

    swfr_mode_t         mode_reg, mode_next;
    logic [RUN_W-1:0]   sync_run_reg, sync_run_next;
    logic [INDEX_W-1:0] frame_pos_reg, frame_pos_next;
    logic [BYTE_W-1:0]  xor_acc_reg, xor_acc_next;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HUNT;
            sync_run_reg  <= '0;
            frame_pos_reg <= '0;
            xor_acc_reg   <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            sync_run_reg  <= sync_run_next;
            frame_pos_reg <= frame_pos_next;
            xor_acc_reg   <= xor_acc_next;
        end
    end

    // Next state and the result for the byte in this request.
    always_comb
    begin
        mode_next      = mode_reg;
        sync_run_next  = sync_run_reg;
        frame_pos_next = frame_pos_reg;
        xor_acc_next   = xor_acc_reg;
        res_valid      = 1'b0;
        res.data_byte  = rx_byte;
        res.byte_index = frame_pos_reg;
        res.last       = 1'b0;
        res.frame_good = 1'b0;

        if (accept)
        begin
            if (rx_error)
            begin
                // A line error drops the byte and restarts the hunt.
                mode_next      = MODE_HUNT;
                sync_run_next  = '0;
                frame_pos_next = '0;
                xor_acc_next   = '0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_HUNT:
                    begin
                        if (rx_byte == sync_byte)
                        begin
                            if (sync_run_reg == RUN_LAST)
                            begin
                                mode_next      = MODE_FRAME;
                                sync_run_next  = '0;
                                frame_pos_next = '0;
                                xor_acc_next   = '0;
                            end
                            else
                            begin
                                sync_run_next = sync_run_reg + RUN_W'(1);
                            end
                        end
                        else
                        begin
                            sync_run_next = '0;
                        end
                    end
                    MODE_FRAME:
                    begin
                        res_valid = 1'b1;
                        if (frame_pos_reg == LAST_POS)
                        begin
                            // Checksum byte closes the frame.
                            res.last       = 1'b1;
                            res.frame_good = (rx_byte == xor_acc_reg);
                            mode_next      = MODE_HUNT;
                            sync_run_next  = '0;
                            frame_pos_next = '0;
                            xor_acc_next   = '0;
                        end
                        else
                        begin
                            xor_acc_next   = xor_acc_reg ^ rx_byte;
                            frame_pos_next = frame_pos_reg + INDEX_W'(1);
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_HUNT;
                    end
                endcase
            end
        end
    end

endmodule

FILE: hdl/swfr_out_stage.sv
// Result register that holds one frame result until the sink takes it.
// Depends on swfr_pkg and the swfr_out_if interface.
module swfr_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  swfr_pkg::swfr_result_t res,
    output logic                   free,
    swfr_out_if.source             out_ch
);
    import swfr_pkg::*;

    logic         valid_reg;
    swfr_result_t res_reg;

    // The register can take a new result when empty or being drained now.
    assign free = !valid_reg || out_ch.ready;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid      = valid_reg;
    assign out_ch.data_byte  = res_reg.data_byte;
    assign out_ch.byte_index = res_reg.byte_index;
    assign out_ch.last       = res_reg.last;
    assign out_ch.frame_good = res_reg.frame_good;

endmodule
